/* src/ect_pkg.sv */
// shared types and constants for the execution coverage tracker
// item and result beats, operation and event codes, per-byte flag bits
package ect_pkg;

  typedef enum logic [1:0] {
    OP_RECORD  = 2'd0,
    OP_WRITE   = 2'd1,
    OP_BLOCKED = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_SELF_MOD = 2'd1,
    EV_BLOCKED  = 2'd2
  } kind_t;

  localparam logic [3:0] FLAG_OPCODE   = 4'b0001;
  localparam logic [3:0] FLAG_OPERAND  = 4'b0010;
  localparam logic [3:0] FLAG_SELF_MOD = 4'b0100;
  localparam logic [3:0] FLAG_BLOCKED  = 4'b1000;
  localparam logic [3:0] FLAG_EXEC     = 4'b0011;

  localparam int FLAG_BITS = 4;

  // register index taken from paddr[2]
  localparam logic REG_BREAK_ON_SELF_MODIFY = 1'b0;

  typedef struct packed {
    op_t         operation;
    logic [15:0] address;
    logic [2:0]  length;
    logic [7:0]  old_byte;
    logic [7:0]  new_byte;
    logic        cpu_instruction_access;
    logic [15:0] instruction_pc;
  } item_t;

  typedef struct packed {
    kind_t       event_kind;
    logic [15:0] event_address;
    logic [7:0]  event_old;
    logic [7:0]  event_new;
    logic [15:0] event_pc;
    logic        break_request;
    logic [16:0] covered_total;
    logic [31:0] self_modify_total;
    logic [31:0] blocked_total;
  } result_t;

endpackage

/* src/exec_coverage_smc_tracker_core.sv */
// Execution coverage and self-modifying write tracker, top level.
// Input beats (s_*) carry one operation each: record executed instruction,
// memory write, blocked write or clear. Every input beat yields exactly one
// result beat (m_*) with the event details and the running totals.
// The flag map (4 bits per byte of a 2^ADDR_BITS space) sits in one
// synchronous ram; clear zeroes it, other operations read and update the flags.
// Map bytes handled from input beat to result beat:
//   record: n map bytes, n = clipped instruction length (1..MAX_INSTR_LEN),
//           one cycle per map byte through the ram read/write ports;
//           only the start byte when it already holds the opcode flag
//   memory write, blocked write: the start byte only
//   clear: the whole map of 2^ADDR_BITS entries, one map entry cleared per cycle
// After reset the map is swept to zero with s_tready low; the config port
// works throughout.
// One operation is in flight at a time. A finished result waits in the
// output register while the next beat is accepted; if m_tready stays low,
// the following result holds inside until the output register frees.
// break_on_self_modify sits at byte address 0 of the apb port.
// Uses ect_pkg and ect_engine.
module exec_coverage_smc_tracker_core #(
  parameter int ADDR_BITS     = 16,
  parameter int MAX_INSTR_LEN = 4,
  parameter int COUNT_BITS    = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_tvalid,
  output logic         s_tready,
  // address, length, old byte, new byte, cpu_instruction_access,
  // instruction_pc, zero pad
  input  logic [55:0]  s_tdata,
  // operation
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // event_address, event_old, event_new, event_pc, break_request,
  // covered_total, self_modify_total, blocked_total, zero pad
  output logic [135:0] m_tdata,
  // event_kind
  output logic [1:0]   m_tuser
);
  import ect_pkg::*;

  logic    break_on_self_modify;
  item_t   in_item;
  result_t out_result;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BREAK_ON_SELF_MODIFY) ? {31'd0, break_on_self_modify}
                                                          : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      break_on_self_modify <= 1'b0;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == REG_BREAK_ON_SELF_MODIFY) begin
      break_on_self_modify <= pwdata[0];
    end
  end

  assign in_item.operation              = op_t'(s_tuser);
  assign in_item.address                = s_tdata[15:0];
  assign in_item.length                 = s_tdata[18:16];
  assign in_item.old_byte               = s_tdata[26:19];
  assign in_item.new_byte               = s_tdata[34:27];
  assign in_item.cpu_instruction_access = s_tdata[35];
  assign in_item.instruction_pc         = s_tdata[51:36];

  ect_engine #(
    .ADDR_BITS     (ADDR_BITS),
    .MAX_INSTR_LEN (MAX_INSTR_LEN),
    .COUNT_BITS    (COUNT_BITS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .break_en   (break_on_self_modify),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (out_result)
  );

  assign m_tuser = out_result.event_kind;
  assign m_tdata = {6'd0,
                    out_result.blocked_total,
                    out_result.self_modify_total,
                    out_result.covered_total,
                    out_result.break_request,
                    out_result.event_pc,
                    out_result.event_new,
                    out_result.event_old,
                    out_result.event_address};

endmodule

/* src/ect_ram.sv */
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module ect_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/ect_engine.sv */
// flag map sequencer: read-modify-write of the coverage map, counters, result beat
// uses ect_pkg and ect_ram
module ect_engine #(
  parameter int ADDR_BITS     = 16,
  parameter int MAX_INSTR_LEN = 4,
  parameter int COUNT_BITS    = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            break_en,
  input  logic            in_valid,
  output logic            in_ready,
  input  ect_pkg::item_t  in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output ect_pkg::result_t out_result
);
  import ect_pkg::*;

  localparam int IDX_BITS = (MAX_INSTR_LEN > 1) ? $clog2(MAX_INSTR_LEN) : 1;
  localparam logic [ADDR_BITS:0] MAP_SIZE = {1'b1, {ADDR_BITS{1'b0}}};

  typedef enum logic [1:0] {ST_SWEEP, ST_IDLE, ST_RUN, ST_DONE} state_t;

  state_t                 state;
  op_t                    op;
  logic [ADDR_BITS-1:0]   base;
  logic [IDX_BITS-1:0]    idx;
  logic [IDX_BITS-1:0]    last_idx;
  logic [IDX_BITS-1:0]    last_idx_next;
  logic [7:0]             old_v;
  logic [7:0]             new_v;
  logic                   cpu;
  logic [15:0]            pc;
  logic [ADDR_BITS-1:0]   sweep_addr;
  logic                   sweep_report;
  kind_t                  ev_kind;
  logic                   ev_brk;
  logic [ADDR_BITS:0]     covered;
  logic [COUNT_BITS-1:0]  smc_cnt;
  logic [COUNT_BITS-1:0]  blk_cnt;

  logic                   we;
  logic [ADDR_BITS-1:0]   waddr;
  logic [FLAG_BITS-1:0]   wdata;
  logic [ADDR_BITS-1:0]   raddr;
  logic [FLAG_BITS-1:0]   rdata;
  logic                   run_done;
  logic                   cov_inc;
  logic                   smc_inc;
  logic                   blk_inc;
  kind_t                  kind_next;
  logic                   brk_next;
  logic                   accept;
  logic                   has_event;

  ect_ram #(
    .WIDTH (FLAG_BITS),
    .DEPTH (2 ** ADDR_BITS)
  ) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign has_event = (ev_kind != EV_NONE);

  // next byte is fetched while the current one is written back
  assign raddr = (state == ST_RUN) ? base + ADDR_BITS'(idx) + 1'b1
                                   : ADDR_BITS'(in_item.address);

  always_comb begin
    if (in_item.length == 3'd0) begin
      last_idx_next = '0;
    end else if (int'(in_item.length) > MAX_INSTR_LEN) begin
      last_idx_next = IDX_BITS'(MAX_INSTR_LEN - 1);
    end else begin
      last_idx_next = IDX_BITS'(in_item.length - 3'd1);
    end
  end

  always_comb begin
    we        = 1'b0;
    waddr     = base + ADDR_BITS'(idx);
    wdata     = rdata;
    run_done  = 1'b0;
    cov_inc   = 1'b0;
    smc_inc   = 1'b0;
    blk_inc   = 1'b0;
    kind_next = EV_NONE;
    brk_next  = 1'b0;
    if (state == ST_SWEEP) begin
      we    = 1'b1;
      waddr = sweep_addr;
      wdata = '0;
    end else if (state == ST_RUN) begin
      unique case (op)
        OP_RECORD: begin
          if (idx == '0 && (rdata & FLAG_OPCODE) != '0) begin
            run_done = 1'b1;
          end else begin
            we       = 1'b1;
            wdata    = rdata | ((idx == '0) ? FLAG_OPCODE : FLAG_OPERAND);
            cov_inc  = ((rdata & FLAG_EXEC) == '0) && (covered != MAP_SIZE);
            run_done = (idx == last_idx);
          end
        end
        OP_WRITE: begin
          run_done = 1'b1;
          if (old_v != new_v && cpu && (rdata & FLAG_EXEC) != '0) begin
            we        = 1'b1;
            wdata     = rdata | FLAG_SELF_MOD;
            smc_inc   = 1'b1;
            kind_next = EV_SELF_MOD;
            brk_next  = break_en;
          end
        end
        OP_BLOCKED: begin
          run_done  = 1'b1;
          we        = 1'b1;
          wdata     = rdata | FLAG_BLOCKED;
          blk_inc   = 1'b1;
          kind_next = EV_BLOCKED;
        end
        OP_CLEAR: begin
          run_done = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_SWEEP;
      sweep_addr   <= '0;
      sweep_report <= 1'b0;
      covered      <= '0;
      smc_cnt      <= '0;
      blk_cnt      <= '0;
      out_valid    <= 1'b0;
      ev_kind      <= EV_NONE;
      ev_brk       <= 1'b0;
      idx          <= '0;
    end else begin
      if (out_valid && out_ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_SWEEP: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == '1) begin
            ev_kind <= EV_NONE;
            ev_brk  <= 1'b0;
            state   <= sweep_report ? ST_DONE : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            op       <= in_item.operation;
            base     <= ADDR_BITS'(in_item.address);
            last_idx <= last_idx_next;
            old_v    <= in_item.old_byte;
            new_v    <= in_item.new_byte;
            cpu      <= in_item.cpu_instruction_access;
            pc       <= in_item.instruction_pc;
            idx      <= '0;
            if (in_item.operation == OP_CLEAR) begin
              covered      <= '0;
              smc_cnt      <= '0;
              blk_cnt      <= '0;
              sweep_addr   <= '0;
              sweep_report <= 1'b1;
              state        <= ST_SWEEP;
            end else begin
              state <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (cov_inc) begin
            covered <= covered + 1'b1;
          end
          if (smc_inc && smc_cnt != '1) begin
            smc_cnt <= smc_cnt + 1'b1;
          end
          if (blk_inc && blk_cnt != '1) begin
            blk_cnt <= blk_cnt + 1'b1;
          end
          if (run_done) begin
            ev_kind <= kind_next;
            ev_brk  <= brk_next;
            state   <= ST_DONE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid                    <= 1'b1;
            out_result.event_kind        <= ev_kind;
            out_result.event_address     <= has_event ? 16'(base) : 16'd0;
            out_result.event_old         <= has_event ? old_v : 8'd0;
            out_result.event_new         <= has_event ? new_v : 8'd0;
            out_result.event_pc          <= has_event ? pc : 16'd0;
            out_result.break_request     <= ev_brk;
            out_result.covered_total     <= 17'(covered);
            out_result.self_modify_total <= 32'(smc_cnt);
            out_result.blocked_total     <= 32'(blk_cnt);
            state                        <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule
